// File: hw/rtl/prw_pkg.sv
// ----------------------------------------------------------------------------
// prw_pkg
// Shared constants, types and codes for the timestamp reorder window.
// ----------------------------------------------------------------------------
package prw_pkg;

    localparam int DEPTH          = 16;
    localparam int IDX_W          = $clog2(DEPTH);
    localparam int FILL_W         = $clog2(DEPTH + 1);
    localparam int PTS_W          = 48;
    localparam int TAG_W          = 16;
    localparam int CNT_W          = 5;
    localparam int SW_W           = 5;
    localparam int OVR_W          = 4;
    localparam int WIN_RAW_W      = 5;
    localparam int CFG_DW         = 5;
    localparam int CFG_IW         = 1;
    localparam int DEFAULT_WINDOW = 4;

    localparam logic [CFG_IW-1:0] REG_WINDOW_OVERRIDE = 1'b0;
    localparam logic [CFG_IW-1:0] REG_HEADER_DEPTH    = 1'b1;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic signed [PTS_W-1:0] pts;
        logic [TAG_W-1:0]        tag;
        logic [CNT_W-1:0]        cnt;
    } t_entry;

    typedef struct packed {
        logic             wr_en;
        logic             wr_from_in;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic             rd_scan;
        logic [IDX_W-1:0] rd_addr;
        logic             scan_start;
        logic             mask_clr;
        logic             mask_set;
        logic             emit;
        logic             emit_last;
    } t_cmd;

    typedef struct packed {
        logic             out_busy;
        logic [IDX_W-1:0] best_idx;
    } t_sts;

endpackage

// File: hw/rtl/prw_if.sv
// ----------------------------------------------------------------------------
// prw_if
// Valid/ready channels for packet results in and released entries out.
// ----------------------------------------------------------------------------
interface prw_in_if;
    import prw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic signed [PTS_W-1:0] pts_ms;
    logic [TAG_W-1:0]        payload_tag;
    logic [CNT_W-1:0]        triplet_cnt;
    logic signed [SW_W-1:0]  stream_window;

    modport source (
        output valid, operation, pts_ms, payload_tag, triplet_cnt, stream_window,
        input  ready
    );
    modport sink (
        input  valid, operation, pts_ms, payload_tag, triplet_cnt, stream_window,
        output ready
    );
endinterface

interface prw_out_if;
    import prw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [PTS_W-1:0] out_pts_ms;
    logic [TAG_W-1:0]        out_tag;
    logic [CNT_W-1:0]        out_count;
    logic                    last;

    modport source (
        output valid, out_pts_ms, out_tag, out_count, last,
        input  ready
    );
    modport sink (
        input  valid, out_pts_ms, out_tag, out_count, last,
        output ready
    );
endinterface

// File: hw/rtl/pts_reorder_window.sv
// ----------------------------------------------------------------------------
// pts_reorder_window
// Timestamp reorder buffer that releases caption entries in time order.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake           Contents
//  i_in      in   valid/ready         operation, pts_ms, payload_tag,
//                                     triplet_cnt, stream_window
//  o_out     out  valid/ready         out_pts_ms, out_tag, out_count, last
//  i_cfg_*   in   write enable only   register index, write data
//
//  One transaction is taken at a time. Each release is found by a linear
//  scan of the single-read-port slot memory over every entry held, and a
//  flush does one full scan per released entry. Reset is synchronous and
//  empties the buffer; slot contents are not cleared. A stalled output
//  holds the sequencer in place.
// ----------------------------------------------------------------------------
module pts_reorder_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    prw_in_if.sink                     i_in,
    prw_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [prw_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [prw_pkg::CFG_DW-1:0] i_cfg_data
);
    import prw_pkg::*;

    t_cmd   cmd;
    t_sts   sts;
    t_entry in_entry;
    t_entry out_entry;
    logic   in_ready;

    assign in_entry.pts = i_in.pts_ms;
    assign in_entry.tag = i_in.payload_tag;
    assign in_entry.cnt = i_in.triplet_cnt;
    assign i_in.ready   = in_ready;

    prw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_in_op    (i_in.operation),
        .i_in_cnt   (i_in.triplet_cnt),
        .i_in_sw    (i_in.stream_window),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    prw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_entry  (in_entry),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_entry (out_entry),
        .o_out_last  (o_out.last),
        .o_sts       (sts)
    );

    assign o_out.out_pts_ms = out_entry.pts;
    assign o_out.out_tag    = out_entry.tag;
    assign o_out.out_count  = out_entry.cnt;

endmodule

// File: hw/rtl/prw_ctrl.sv
// ----------------------------------------------------------------------------
// prw_ctrl
// Sequencer: configuration registers, fill level, window and slot scans.
// ----------------------------------------------------------------------------
module prw_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_in_op,
    input  logic [prw_pkg::CNT_W-1:0]      i_in_cnt,
    input  logic signed [prw_pkg::SW_W-1:0] i_in_sw,
    input  logic                           i_cfg_we,
    input  logic [prw_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic [prw_pkg::CFG_DW-1:0]     i_cfg_data,
    input  prw_pkg::t_sts                  i_sts,
    output prw_pkg::t_cmd                  o_cmd
);
    import prw_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_WAIT    = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;
    localparam logic [2:0] S_MOVE_RD = 3'd5;
    localparam logic [2:0] S_MOVE_WR = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [FILL_W-1:0]       r_remain, n_remain;
    logic [FILL_W-1:0]       r_cnt, n_cnt;
    logic                    r_flush, n_flush;
    logic [IDX_W-1:0]        r_window, n_window;
    logic [OVR_W-1:0]        r_ovr, n_ovr;
    logic signed [SW_W-1:0]  r_hdr, n_hdr;
    logic signed [SW_W-1:0]  r_learned, n_learned;

    logic                    accept;
    logic [WIN_RAW_W-1:0]    win_raw;
    logic [IDX_W-1:0]        win_sat;
    logic [FILL_W-1:0]       fill_m1;
    logic                    last_hit;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign fill_m1    = r_fill - FILL_W'(1);

    // Configuration registers and the learned depth. A header write forgets
    // whatever depth was learned from the stream.
    always_comb begin
        n_ovr     = r_ovr;
        n_hdr     = r_hdr;
        n_learned = r_learned;
        if (accept && i_in_op == OP_PUSH && !i_in_sw[SW_W-1] && r_hdr[SW_W-1]
            && r_learned[SW_W-1]) begin
            n_learned = i_in_sw;
        end
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_OVERRIDE: n_ovr = i_cfg_data[OVR_W-1:0];
                REG_HEADER_DEPTH: begin
                    n_hdr     = $signed(i_cfg_data[SW_W-1:0]);
                    n_learned = -SW_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Window seen by this push, using the depth learned from it.
    always_comb begin
        if (r_ovr != '0) begin
            win_raw = WIN_RAW_W'(r_ovr);
        end else if (!r_hdr[SW_W-1]) begin
            win_raw = WIN_RAW_W'(r_hdr);
        end else if (!n_learned[SW_W-1]) begin
            win_raw = WIN_RAW_W'(n_learned);
        end else begin
            win_raw = WIN_RAW_W'(DEFAULT_WINDOW);
        end
        if (int'(win_raw) > DEPTH - 1) begin
            win_sat = IDX_W'(DEPTH - 1);
        end else begin
            win_sat = IDX_W'(win_raw);
        end
    end

    assign last_hit = r_flush ? (r_remain == FILL_W'(1))
                              : (fill_m1 <= FILL_W'(r_window));

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_remain = r_remain;
        n_cnt    = r_cnt;
        n_flush  = r_flush;
        n_window = r_window;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_op == OP_FLUSH) begin
                        n_flush = 1'b1;
                        if (r_fill != '0) begin
                            n_remain       = r_fill;
                            n_cnt          = '0;
                            o_cmd.mask_clr = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end else begin
                        n_flush        = 1'b0;
                        n_window       = win_sat;
                        o_cmd.mask_clr = 1'b1;
                        if (i_in_cnt != '0 && r_fill < FILL_W'(DEPTH)) begin
                            o_cmd.wr_en      = 1'b1;
                            o_cmd.wr_from_in = 1'b1;
                            o_cmd.wr_addr    = r_fill[IDX_W-1:0];
                            n_fill           = r_fill + FILL_W'(1);
                        end
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_fill > FILL_W'(r_window)) begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_scan    = 1'b1;
                o_cmd.rd_addr    = r_cnt[IDX_W-1:0];
                o_cmd.scan_start = (r_cnt == '0);
                if (r_cnt == fill_m1) begin
                    n_state = S_WAIT;
                end else begin
                    n_cnt = r_cnt + FILL_W'(1);
                end
            end
            S_WAIT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = last_hit;
                    if (r_flush) begin
                        o_cmd.mask_set = 1'b1;
                        n_remain       = r_remain - FILL_W'(1);
                        if (last_hit) begin
                            n_fill  = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_state = S_MOVE_RD;
                    end
                end
            end
            S_MOVE_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = fill_m1[IDX_W-1:0];
                n_state       = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                // The last slot fills the hole left by the released entry.
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = i_sts.best_idx;
                n_fill        = fill_m1;
                n_state       = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_remain  <= '0;
            r_cnt     <= '0;
            r_flush   <= 1'b0;
            r_window  <= '0;
            r_ovr     <= '0;
            r_hdr     <= -SW_W'(1);
            r_learned <= -SW_W'(1);
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_remain  <= n_remain;
            r_cnt     <= n_cnt;
            r_flush   <= n_flush;
            r_window  <= n_window;
            r_ovr     <= n_ovr;
            r_hdr     <= n_hdr;
            r_learned <= n_learned;
        end
    end

endmodule

// File: hw/rtl/prw_dp.sv
// ----------------------------------------------------------------------------
// prw_dp
// Slot memory, minimum search, flush mask and output register.
// ----------------------------------------------------------------------------
module prw_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prw_pkg::t_cmd   i_cmd,
    input  prw_pkg::t_entry i_in_entry,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output prw_pkg::t_entry o_out_entry,
    output logic            o_out_last,
    output prw_pkg::t_sts   o_sts
);
    import prw_pkg::*;

    t_entry           r_mem [DEPTH];
    t_entry           r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_scan_vld;
    logic [DEPTH-1:0] r_mask;
    t_entry           r_best;
    logic [IDX_W-1:0] r_best_idx;
    logic             r_best_vld;
    logic             r_out_vld;
    t_entry           r_out;
    logic             r_out_last;

    logic             take;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_from_in ? i_in_entry : r_rd_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
        r_rd_idx <= i_cmd.rd_addr;
    end

    // Strict less-than keeps the lowest slot on equal timestamps. During a
    // flush, entries already released are masked out of the search.
    assign take = r_scan_vld && !r_mask[r_rd_idx]
                  && (!r_best_vld || ($signed(r_rd_data.pts) < $signed(r_best.pts)));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best     <= r_rd_data;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.emit) begin
            r_out      <= r_best;
            r_out_last <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld <= 1'b0;
            r_best_vld <= 1'b0;
            r_mask     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_scan_vld <= i_cmd.rd_en && i_cmd.rd_scan;
            if (i_cmd.scan_start) begin
                r_best_vld <= 1'b0;
            end else if (take) begin
                r_best_vld <= 1'b1;
            end
            if (i_cmd.mask_clr) begin
                r_mask <= '0;
            end else if (i_cmd.mask_set) begin
                r_mask[r_best_idx] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_out_entry    = r_out;
    assign o_out_last     = r_out_last;
    assign o_sts.out_busy = r_out_vld && !i_out_ready;
    assign o_sts.best_idx = r_best_idx;

endmodule

// File: hw/rtl/prw_checker.sv
// ----------------------------------------------------------------------------
// prw_checker
// Port-level assertions for the timestamp reorder window.
// ----------------------------------------------------------------------------
module prw_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_in_op,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [prw_pkg::PTS_W-1:0]  i_out_pts_ms,
    input logic [prw_pkg::TAG_W-1:0]         i_out_tag,
    input logic [prw_pkg::CNT_W-1:0]         i_out_count,
    input logic                              i_out_last
);
    import prw_pkg::*;

    // Every push keeps the input not ready directly after it is accepted.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == OP_PUSH |=> !i_in_ready)
        else $error("push accepted on consecutive cycles");

    // Only entries with captions are ever stored, so none is released empty.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_count != '0)
        else $error("released entry has zero caption count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pts_ms)
            && $stable(i_out_tag) && $stable(i_out_count) && $stable(i_out_last))
        else $error("stalled output transaction changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind pts_reorder_window prw_checker u_prw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_op      (i_in.operation),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_pts_ms (o_out.out_pts_ms),
    .i_out_tag    (o_out.out_tag),
    .i_out_count  (o_out.out_count),
    .i_out_last   (o_out.last)
);
